// ===== rtl/fpr_pkg.sv =====
package fpr_pkg;

  localparam int FRAMES     = 16;
  localparam int PAGE_BITS  = 16;
  localparam int SLOT_W     = 4;
  localparam int CNT_W      = 32;
  localparam int NCFG_W     = 5;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 88;
  localparam int OUT_USER_W = 2;

  localparam logic [NCFG_W-1:0] FRAMES_RESET = NCFG_W'(FRAMES);
  localparam logic [CNT_W-1:0]  CNT_MAX      = {CNT_W{1'b1}};

  typedef struct packed {
    logic capture;  // latch the accepted reference
    logic exec;     // look up, update frames and load the result
  } fpr_cmd_t;

  typedef struct packed {
    logic out_free; // result register empty or being drained this cycle
  } fpr_sts_t;

endpackage

// ===== rtl/fpr_ctrl.sv =====
module fpr_ctrl
  import fpr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  fpr_sts_t sts,
  output fpr_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready   = (state_r == S_IDLE);
  assign cmd.capture = in_tvalid && (state_r == S_IDLE);
  assign cmd.exec    = (state_r == S_EXEC) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/fpr_datapath.sv =====
module fpr_datapath
  import fpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  fpr_cmd_t              cmd,
  output fpr_sts_t              sts,
  input  logic                  cfg_wr_en,
  input  logic [NCFG_W-1:0]     cfg_wr_data,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tlast
);

  logic [NCFG_W-1:0]    frames_cfg_r;
  logic [PAGE_BITS-1:0] page_r;
  logic                 last_r;
  logic [PAGE_BITS-1:0] frame_page_r [FRAMES];
  logic [FRAMES-1:0]    frame_valid_r;
  logic [SLOT_W-1:0]    next_slot_r;
  logic [CNT_W-1:0]     hits_r;
  logic [CNT_W-1:0]     misses_r;

  logic                 out_valid_r;
  logic                 res_hit_r;
  logic [SLOT_W-1:0]    res_slot_r;
  logic                 res_ev_valid_r;
  logic [PAGE_BITS-1:0] res_ev_page_r;
  logic [CNT_W-1:0]     res_hits_r;
  logic [CNT_W-1:0]     res_misses_r;
  logic                 res_last_r;

  logic [NCFG_W-1:0]    n_act;
  logic [FRAMES-1:0]    match;
  logic                 hit;
  logic [SLOT_W-1:0]    hit_slot;
  logic [SLOT_W-1:0]    fill_slot;
  logic [SLOT_W-1:0]    slot;
  logic [NCFG_W-1:0]    fill_inc;
  logic [SLOT_W-1:0]    ptr_nxt;
  logic                 ev_valid;
  logic [PAGE_BITS-1:0] ev_page;
  logic [CNT_W-1:0]     hits_nxt;
  logic [CNT_W-1:0]     misses_nxt;

  // clamp the configured frame count into 1..FRAMES
  always_comb begin
    if (frames_cfg_r == '0) begin
      n_act = NCFG_W'(1);
    end else if (frames_cfg_r > NCFG_W'(FRAMES)) begin
      n_act = NCFG_W'(FRAMES);
    end else begin
      n_act = frames_cfg_r;
    end
  end

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match[i] = frame_valid_r[i] && (frame_page_r[i] == page_r) && (NCFG_W'(i) < n_act);
    end
  end

  // lowest matching frame wins
  always_comb begin
    hit_slot = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match[i]) hit_slot = SLOT_W'(i);
    end
  end

  assign hit       = |match;
  assign fill_slot = ({1'b0, next_slot_r} < n_act) ? next_slot_r : '0;
  assign fill_inc  = {1'b0, fill_slot} + NCFG_W'(1);
  assign ptr_nxt   = (fill_inc == n_act) ? '0 : fill_inc[SLOT_W-1:0];
  assign slot      = hit ? hit_slot : fill_slot;
  assign ev_valid  = !hit && frame_valid_r[fill_slot];
  assign ev_page   = ev_valid ? frame_page_r[fill_slot] : '0;
  assign hits_nxt   = (hit && hits_r != CNT_MAX) ? hits_r + CNT_W'(1) : hits_r;
  assign misses_nxt = (!hit && misses_r != CNT_MAX) ? misses_r + CNT_W'(1) : misses_r;

  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_cfg_r <= FRAMES_RESET;
    end else if (cfg_wr_en) begin
      frames_cfg_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_r <= in_tdata[PAGE_BITS-1:0];
      last_r <= in_tlast;
    end
  end

  // frame contents need no reset: each is read only behind its valid bit
  always_ff @(posedge clk) begin
    if (cmd.exec && !hit && !last_r) begin
      frame_page_r[fill_slot] <= page_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= '0;
      next_slot_r   <= '0;
      hits_r        <= '0;
      misses_r      <= '0;
    end else if (cmd.exec) begin
      if (last_r) begin
        frame_valid_r <= '0;
        next_slot_r   <= '0;
        hits_r        <= '0;
        misses_r      <= '0;
      end else begin
        hits_r   <= hits_nxt;
        misses_r <= misses_nxt;
        if (!hit) begin
          frame_valid_r[fill_slot] <= 1'b1;
          next_slot_r              <= ptr_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_hit_r      <= hit;
      res_slot_r     <= slot;
      res_ev_valid_r <= ev_valid;
      res_ev_page_r  <= ev_page;
      res_hits_r     <= hits_nxt;
      res_misses_r   <= misses_nxt;
      res_last_r     <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, res_misses_r, res_hits_r, res_ev_page_r, res_slot_r};
  assign out_tuser  = {res_ev_valid_r, res_hit_r};
  assign out_tlast  = res_last_r;

endmodule

// ===== rtl/fifo_page_replacement.sv =====
// channel  | ports               | contents
// ---------+---------------------+---------------------------------------------
// in       | in_tvalid/tready    | tdata: page; tlast: last_ref
// out      | out_tvalid/tready   | tdata: slot, evicted_page, hit_count,
//          |                     |   miss_count; tuser: hit, evicted_valid;
//          |                     |   tlast: run_done
// cfg      | cfg_wr_en           | cfg_wr_data: frames_in_use
//
// Each reference is first latched, then the parallel frame compare and update
// loads the result register.
// A new reference is taken while the previous result still waits at the output.
// Reset is synchronous, active low: all frames empty, pointer and counts zero,
// frames_in_use set to 16. A stalled output holds the lookup step.
module fifo_page_replacement
  import fpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [NCFG_W-1:0]     cfg_wr_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] page
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [3:0] slot, [19:4] evicted_page,
                                            // [51:20] hit_count, [83:52] miss_count
  output logic [OUT_USER_W-1:0] out_tuser,  // [0] hit, [1] evicted_valid
  output logic                  out_tlast
);

  fpr_cmd_t cmd;
  fpr_sts_t sts;

  fpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpr_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule
